>>> hw/rtl/assert_macros.svh
// Assertion macros for the top-level RTL file of the deque block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/deq_pkg.sv
// Package of the deque block: sizes, command codes and the cell control bundle.
package deq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned OCC_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_DEL_HEAD = 3'd2,
    CMD_DEL_TAIL = 3'd3,
    CMD_SEARCH   = 3'd4,
    CMD_REPLACE  = 3'd5
  } cmd_e;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic              shift_in;   // move every entry one place toward the tail
    logic              shift_out;  // move every entry one place toward the head
    logic              put_tail;   // the cell just past the tail takes the key
    logic              replace;    // the first matching cell takes new_value
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] new_value;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/deq_cell.sv
// One storage cell of the deque: holds an entry, compares it and shifts with its neighbors.
module deq_cell import deq_pkg::*; (
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  input  logic              found_i,
  output logic [DATA_W-1:0] value_o,
  output logic              found_o,
  output logic              last_o
);

  logic [DATA_W-1:0] value_q, value_d;
  logic [CNT_W-1:0]  pos;
  logic              occupied;
  logic              hit;

  assign pos      = CNT_W'(idx_i);
  assign occupied = pos < ctrl_i.count;
  assign hit      = occupied && (value_q == ctrl_i.key);
  assign found_o  = found_i | hit;
  assign last_o   = (pos + CNT_W'(1)) == ctrl_i.count;
  assign value_o  = value_q;

  always_comb begin
    value_d = value_q;
    priority if (ctrl_i.shift_in) begin
      value_d = left_i;
    end else if (ctrl_i.shift_out) begin
      value_d = right_i;
    end else if (ctrl_i.put_tail && (pos == ctrl_i.count)) begin
      value_d = ctrl_i.key;
    end else if (ctrl_i.replace && hit && !found_i) begin
      // Only the match nearest the head is rewritten.
      value_d = ctrl_i.new_value;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

>>> hw/rtl/deque_with_search_replace.sv
// Top level of the deque: command decode, the row of cells, count and result register.
`include "assert_macros.svh"

// A bounded double-ended queue of up to 16 signed 32-bit entries, kept in a row of cells
// with the head in cell 0. Commands are insert or delete at either end, search, and replace
// of the first match from the head. A new command is accepted in every cycle in which the
// result register is empty or being read. Its result is registered and appears in the cycle
// after acceptance. The clock period is set by the match chain that runs from the head cell
// to the last cell for search and replace. Each result carries the success flag, the head
// and tail entries after the command (zero when empty) and the number of entries.
module deque_with_search_replace import deq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] value, [63:32] new_value
  input  logic [63:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] ok, [32:1] head_value, [64:33] tail_value, [69:65] occupancy, [71:70] zero
  output logic [71:0] m_axis_tdata
);

  logic              in_acc;
  cmd_e              cmd;
  logic [DATA_W-1:0] in_value, in_new_value;
  logic              full, empty;
  logic              ok_d, ok_q;
  logic              out_valid_q;
  logic [CNT_W-1:0]  count_q, count_d;
  cell_ctrl_t        ctrl;

  logic [DATA_W-1:0] cell_value [DEPTH];
  logic              cell_last  [DEPTH];
  logic              found      [DEPTH+1];
  logic [DATA_W-1:0] head_value, tail_value;

  assign cmd          = cmd_e'(s_axis_tuser);
  assign in_value     = s_axis_tdata[31:0];
  assign in_new_value = s_axis_tdata[63:32];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign full  = count_q == CNT_W'(DEPTH);
  assign empty = count_q == '0;

  always_comb begin
    ctrl           = '0;
    ctrl.key       = in_value;
    ctrl.new_value = in_new_value;
    ctrl.count     = count_q;
    count_d        = count_q;
    ok_d           = 1'b0;
    unique case (cmd)
      CMD_INS_HEAD: begin
        ok_d          = !full;
        ctrl.shift_in = in_acc && !full;
        if (in_acc && !full) count_d = count_q + CNT_W'(1);
      end
      CMD_INS_TAIL: begin
        ok_d          = !full;
        ctrl.put_tail = in_acc && !full;
        if (in_acc && !full) count_d = count_q + CNT_W'(1);
      end
      CMD_DEL_HEAD: begin
        ok_d           = !empty;
        ctrl.shift_out = in_acc && !empty;
        if (in_acc && !empty) count_d = count_q - CNT_W'(1);
      end
      CMD_DEL_TAIL: begin
        ok_d = !empty;
        if (in_acc && !empty) count_d = count_q - CNT_W'(1);
      end
      CMD_SEARCH: begin
        ok_d = found[DEPTH];
      end
      CMD_REPLACE: begin
        ok_d         = found[DEPTH];
        ctrl.replace = in_acc;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  assign found[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = in_value;
    end else begin : g_mid
      assign left_v = cell_value[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign right_v = cell_value[g];
    end else begin : g_inner
      assign right_v = cell_value[g+1];
    end

    deq_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .ctrl_i  (ctrl),
      .left_i  (left_v),
      .right_i (right_v),
      .found_i (found[g]),
      .value_o (cell_value[g]),
      .found_o (found[g+1]),
      .last_o  (cell_last[g])
    );
  end

  // Exactly one cell flags itself as the tail when the deque is not empty.
  always_comb begin
    tail_value = '0;
    for (int k = 0; k < DEPTH; k++) begin
      tail_value = tail_value | (cell_value[k] & {DATA_W{cell_last[k]}});
    end
  end

  assign head_value = empty ? '0 : cell_value[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
        ok_q        <= ok_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The state changes only on an accepted item, so head, tail and count still match ok_q.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, OCC_W'(count_q), tail_value, head_value, ok_q};

  `ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(DEPTH))
  `ASSERT_NEXT(a_full_insert_rejected, clk_i, rst_ni, in_acc && full && (cmd == CMD_INS_HEAD || cmd == CMD_INS_TAIL), !ok_q && count_q == CNT_W'(DEPTH))
  `ASSERT_NEXT(a_delete_shrinks, clk_i, rst_ni, in_acc && !empty && (cmd == CMD_DEL_HEAD || cmd == CMD_DEL_TAIL), ok_q && count_q == $past(count_q) - CNT_W'(1))
  `ASSERT_IMPL(a_empty_reads_zero, clk_i, rst_ni, empty, head_value == '0 && tail_value == '0)

endmodule

>>> tb/deque_with_search_replace_checker.sv
// Checker for the deque: watches both streams, predicts each result and compares it.
`timescale 1ns / 1ps

module deque_with_search_replace_checker import deq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [31:0] value, [63:32] new_value
  input  logic [63:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] ok, [32:1] head_value, [64:33] tail_value, [69:65] occupancy, [71:70] zero
  input  logic [71:0] m_axis_tdata,
  input  logic        end_i,
  output int          pending_o,
  output int          mismatches_o
);

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] head;
    logic signed [DATA_W-1:0] tail;
    logic [OCC_W-1:0]         occ;
  } deque_result_t;

  logic signed [DATA_W-1:0] entries [DEPTH];
  int                       entry_count;
  deque_result_t            expected_results [$];
  bit                       ended;
  int n_commands, n_results, n_full_rejects, n_empty_rejects, n_hits, n_unused, peak_occ;

  assign pending_o = expected_results.size();

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches_o++;
  endtask

  // Applies one command to the shadow deque and returns the result it should give.
  function automatic deque_result_t apply_command(input logic [CMD_W-1:0] code,
                                                  input logic signed [DATA_W-1:0] key,
                                                  input logic signed [DATA_W-1:0] repl);
    deque_result_t r;
    int i;
    logic found;
    r = '0;
    found = 1'b0;
    case (code)
      CMD_INS_HEAD: begin
        if (entry_count < DEPTH) begin
          for (i = entry_count; i > 0; i--) entries[i] = entries[i-1];
          entries[0] = key;
          entry_count++;
          r.ok = 1'b1;
        end
      end
      CMD_INS_TAIL: begin
        if (entry_count < DEPTH) begin
          entries[entry_count] = key;
          entry_count++;
          r.ok = 1'b1;
        end
      end
      CMD_DEL_HEAD: begin
        if (entry_count > 0) begin
          for (i = 0; i + 1 < entry_count; i++) entries[i] = entries[i+1];
          entry_count--;
          r.ok = 1'b1;
        end
      end
      CMD_DEL_TAIL: begin
        if (entry_count > 0) begin
          entry_count--;
          r.ok = 1'b1;
        end
      end
      CMD_SEARCH: begin
        for (i = 0; i < entry_count; i++) begin
          if (!found && entries[i] == key) found = 1'b1;
        end
        r.ok = found;
      end
      CMD_REPLACE: begin
        for (i = 0; i < entry_count; i++) begin
          if (!found && entries[i] == key) begin
            entries[i] = repl;
            found = 1'b1;
          end
        end
        r.ok = found;
      end
      default: begin
      end
    endcase
    if (entry_count > 0) begin
      r.head = entries[0];
      r.tail = entries[entry_count-1];
    end
    r.occ = entry_count[OCC_W-1:0];
    return r;
  endfunction

  // Inputs only move at the rising edge, so the falling edge sees the values that the
  // next rising edge will act on. Results are compared before the new item is predicted,
  // since a result leaving at an edge always belongs to an earlier item.
  always @(negedge clk_i) begin
    deque_result_t exp_r;
    deque_result_t new_r;
    logic [CMD_W-1:0] code;
    if (!rst_ni) begin
      entry_count = 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %h with no command waiting", m_axis_tdata));
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tdata[0] !== exp_r.ok)
            report_mismatch($sformatf("ok got %b want %b", m_axis_tdata[0], exp_r.ok));
          if (m_axis_tdata[32:1] !== exp_r.head)
            report_mismatch($sformatf("head_value got %0d want %0d",
                                      $signed(m_axis_tdata[32:1]), exp_r.head));
          if (m_axis_tdata[64:33] !== exp_r.tail)
            report_mismatch($sformatf("tail_value got %0d want %0d",
                                      $signed(m_axis_tdata[64:33]), exp_r.tail));
          if (m_axis_tdata[69:65] !== exp_r.occ)
            report_mismatch($sformatf("occupancy got %0d want %0d",
                                      m_axis_tdata[69:65], exp_r.occ));
          if (m_axis_tdata[71:70] !== 2'b00)
            report_mismatch($sformatf("padding bits got %b", m_axis_tdata[71:70]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        code = s_axis_tuser;
        n_commands++;
        new_r = apply_command(code, s_axis_tdata[31:0], s_axis_tdata[63:32]);
        expected_results.push_back(new_r);
        if (entry_count > peak_occ) peak_occ = entry_count;
        if (!new_r.ok) begin
          case (code)
            CMD_INS_HEAD, CMD_INS_TAIL: n_full_rejects++;
            CMD_DEL_HEAD, CMD_DEL_TAIL: n_empty_rejects++;
            CMD_SEARCH, CMD_REPLACE: ;
            default: n_unused++;
          endcase
        end else if (code == CMD_SEARCH || code == CMD_REPLACE) begin
          n_hits++;
        end
      end
      if (end_i && !ended) begin
        ended = 1'b1;
        while (expected_results.size() != 0) begin
          exp_r = expected_results.pop_front();
          report_mismatch($sformatf("result never arrived, want occupancy %0d", exp_r.occ));
        end
        $display("Covered %0d commands and %0d results, peak occupancy %0d.",
                 n_commands, n_results, peak_occ);
        $display("Full rejects %0d, empty rejects %0d, hits %0d, unused codes %0d.",
                 n_full_rejects, n_empty_rejects, n_hits, n_unused);
      end
    end
  end

endmodule

>>> tb/deque_with_search_replace_tb.sv
// Testbench top for the deque: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module deque_with_search_replace_tb;
  import deq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_ONES = 32'hFFFF_FFFF;

  typedef enum int { MODE_FILL, MODE_DRAIN, MODE_MIX } traffic_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        end_of_run;
  int          pending;
  int          mismatches;
  int          tx_idle_pct;
  int          rx_stall_pct;
  logic [DATA_W-1:0] value_pool [8];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  deque_with_search_replace uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  deque_with_search_replace_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .end_i(end_of_run), .pending_o(pending), .mismatches_o(mismatches)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Called right after a rising edge; returns right after the edge that took the item.
  task automatic send_item(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] key,
                           input logic [DATA_W-1:0] repl);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {repl, key};
    s_axis_tuser  <= code;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  function automatic logic [CMD_W-1:0] pick_command(input traffic_mode_e mode);
    int r;
    int ins_pct;
    int del_pct;
    r = $urandom_range(99);
    ins_pct = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 15 : 35;
    del_pct = (mode == MODE_FILL) ? 15 : (mode == MODE_DRAIN) ? 65 : 35;
    if (r < ins_pct) return $urandom_range(1) ? CMD_INS_HEAD : CMD_INS_TAIL;
    r -= ins_pct;
    if (r < del_pct) return $urandom_range(1) ? CMD_DEL_HEAD : CMD_DEL_TAIL;
    r -= del_pct;
    if (r < 17) return $urandom_range(1) ? CMD_SEARCH : CMD_REPLACE;
    return $urandom_range(1) ? CMD_UNUSED_LO : CMD_UNUSED_HI;
  endfunction

  // Values mostly come from a small pool so that searches and replaces find matches.
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return value_pool[$urandom_range(7)];
    if (r < 65) begin
      case ($urandom_range(3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_ONES;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic run_random(input int count);
    traffic_mode_e mode;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) mode = traffic_mode_e'($urandom_range(2));
      send_item(pick_command(mode), pick_value(), pick_value());
    end
  endtask

  initial begin
    int waited;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_INS_HEAD;
    end_of_run    <= 1'b0;
    tx_idle_pct   = 7;
    rx_stall_pct  <= 70;
    foreach (value_pool[k]) value_pool[k] = $urandom;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty store first: every delete is refused and head and tail read zero; then both ends fill.
    send_item(CMD_DEL_HEAD, '0, '0);
    send_item(CMD_DEL_TAIL, '0, '0);
    send_item(CMD_SEARCH, '0, '0);
    send_item(CMD_REPLACE, '0, VAL_MAX);
    send_item(CMD_UNUSED_LO, VAL_ONES, VAL_ONES);
    send_item(CMD_UNUSED_HI, VAL_MIN, VAL_MAX);
    send_item(CMD_INS_HEAD, VAL_MIN, VAL_ONES);
    send_item(CMD_INS_TAIL, VAL_MAX, '0);
    send_item(CMD_INS_HEAD, VAL_ONES, VAL_MIN);
    send_item(CMD_INS_TAIL, '0, VAL_MAX);
    send_item(CMD_INS_TAIL, VAL_ONES, '0);
    send_item(CMD_SEARCH, VAL_MAX, '0);
    send_item(CMD_SEARCH, 32'd5, '0);
    // Two entries hold all ones; only the one nearer the head changes.
    send_item(CMD_REPLACE, VAL_ONES, 32'h1234_5678);
    send_item(CMD_REPLACE, 32'd5, VAL_MIN);
    send_item(CMD_SEARCH, VAL_ONES, '0);
    send_item(CMD_UNUSED_HI, '0, '0);
    send_item(CMD_DEL_HEAD, '0, '0);
    send_item(CMD_DEL_TAIL, '0, '0);
    send_item(CMD_REPLACE, VAL_MIN, VAL_MAX);

    run_random(330);
    tx_idle_pct  = 70;
    rx_stall_pct <= 7;
    run_random(350);
    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    run_random(350);
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    end_of_run <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> deque_with_search_replace.f
+incdir+hw/rtl
hw/rtl/deq_pkg.sv
hw/rtl/deq_cell.sv
hw/rtl/deque_with_search_replace.sv
tb/deque_with_search_replace_checker.sv
tb/deque_with_search_replace_tb.sv
